// ===== src/assert_macros.svh =====
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/rgbbox_pkg.sv =====
package rgbbox_pkg;

  localparam int CHAN_W      = 8;
  localparam int REG_ROWS_W  = 13;
  localparam int REG_COLS_W  = 11;
  localparam int REG_SCALE_W = 5;
  localparam int ROWS_LIMIT  = 4096;
  localparam int ROW_W       = $clog2(ROWS_LIMIT);
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_SCALE = 16;

  localparam logic [REG_ROWS_W-1:0]  ROWS_RST  = REG_ROWS_W'(480);
  localparam logic [REG_COLS_W-1:0]  COLS_RST  = REG_COLS_W'(640);
  localparam logic [REG_SCALE_W-1:0] SCALE_RST = REG_SCALE_W'(2);

  // register index = paddr[3:2]
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;     // pixel transfer this cycle
    logic acc;        // read-modify-write of column sums
    logic div_start;  // load divider with fresh sums
    logic div_step;   // one quotient bit
    logic load;       // move quotient into output register
  } cmd_t;

  typedef struct packed {
    logic in_block;   // current pixel lies in a whole block
    logic last_q;     // latched pixel closes its block
    logic div_done;   // divider on its final step
    logic out_free;   // output register can take a result
  } status_t;

endpackage

// ===== src/rgbbox_ram.sv =====
module rgbbox_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rgbbox_ctrl.sv =====
`include "assert_macros.svh"

module rgbbox_ctrl import rgbbox_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid && st.in_block) state_next = ST_ACC;
      ST_ACC:  state_next = st.last_q ? ST_DIV : ST_IDLE;
      ST_DIV:  if (st.div_done) state_next = ST_LOAD;
      ST_LOAD: if (st.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    s_tready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_ACC: begin
        cmd.acc       = 1'b1;
        cmd.div_start = st.last_q;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_LOAD: cmd.load = st.out_free;
      default: cmd = '0;
    endcase
  end

  `ASSERT_IMPL(a_load_from_div, clk, rst, state == ST_LOAD,
    $past(state) == ST_DIV || $past(state) == ST_LOAD)
  `ASSERT_IMPL(a_acc_after_accept, clk, rst, state == ST_ACC, $past(cmd.accept))
  `ASSERT_PROP(a_one_cmd, clk, rst, $onehot0({cmd.accept, cmd.acc, cmd.div_step, cmd.load}))

endmodule

// ===== src/rgbbox_dp.sv =====
`include "assert_macros.svh"

module rgbbox_dp import rgbbox_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  input  logic [3*CHAN_W-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [3*CHAN_W-1:0]  m_tdata,
  output logic [0:0]           m_tuser,
  input  cmd_t                 cmd,
  output status_t              st
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(MAX_SCALE + 1);
  localparam int WB    = $clog2(MAX_SCALE);
  localparam int ACC_W = CHAN_W + 2 * $clog2(MAX_SCALE);
  localparam int SQ_W  = 2 * SW;
  localparam int CCW   = CW + SW + 2;
  localparam int RCW   = REG_ROWS_W + SW + 2;
  localparam int DCW   = $clog2(ACC_W);

  // ---- configuration registers ----
  logic [REG_ROWS_W-1:0]  rows_reg;
  logic [REG_COLS_W-1:0]  cols_reg;
  logic [REG_SCALE_W-1:0] scale_reg;
  logic                   cfg_wr;
  logic                   cfg_hit;
  logic [1:0]             cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  // only a write to a real register restarts the frame
  assign cfg_hit = cfg_wr
                && (cfg_idx == REG_ROWS || cfg_idx == REG_COLS || cfg_idx == REG_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg  <= ROWS_RST;
      cols_reg  <= COLS_RST;
      scale_reg <= SCALE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROWS:  rows_reg  <= pwdata[REG_ROWS_W-1:0];
        REG_COLS:  cols_reg  <= pwdata[REG_COLS_W-1:0];
        REG_SCALE: scale_reg <= pwdata[REG_SCALE_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROWS:  prdata = PDATA_W'(rows_reg);
      REG_COLS:  prdata = PDATA_W'(cols_reg);
      REG_SCALE: prdata = PDATA_W'(scale_reg);
      default:   prdata = '0;
    endcase
  end

  // ---- effective (clamped) geometry ----
  logic [CCW-1:0] cols_e;
  logic [RCW-1:0] rows_e;
  logic [SW-1:0]  s_e;

  always_comb begin
    if (cols_reg == '0)                  cols_e = CCW'(1);
    else if (int'(cols_reg) > MAX_WIDTH) cols_e = CCW'(MAX_WIDTH);
    else                                 cols_e = CCW'(cols_reg);
    if (rows_reg == '0)                   rows_e = RCW'(1);
    else if (int'(rows_reg) > ROWS_LIMIT) rows_e = RCW'(ROWS_LIMIT);
    else                                  rows_e = RCW'(rows_reg);
    if (scale_reg == '0)                  s_e = SW'(1);
    else if (int'(scale_reg) > MAX_SCALE) s_e = SW'(MAX_SCALE);
    else                                  s_e = SW'(scale_reg);
  end

  // ---- position counters ----
  logic [CW-1:0]    pcol, bcol;
  logic [ROW_W-1:0] prow;
  logic [WB-1:0]    wbc, wbr;
  logic [CCW-1:0]   col_base;
  logic [RCW-1:0]   row_base;

  logic wbc_wrap, wbr_wrap, row_end, frame_end;
  logic first_now, last_now, done_now;

  assign wbc_wrap  = (SW + 1)'(wbc) + 1'b1 >= (SW + 1)'(s_e);
  assign wbr_wrap  = (SW + 1)'(wbr) + 1'b1 >= (SW + 1)'(s_e);
  assign row_end   = CCW'(pcol) + 1'b1 >= cols_e;
  assign frame_end = RCW'(prow) + 1'b1 >= rows_e;

  assign st.in_block = (col_base + CCW'(s_e) <= cols_e) && (row_base + RCW'(s_e) <= rows_e);
  assign first_now = (wbc == '0) && (wbr == '0);
  assign last_now  = wbc_wrap && wbr_wrap;
  // last block column and last block row: no second block fits beyond
  assign done_now  = (col_base + CCW'({s_e, 1'b0}) > cols_e)
                  && (row_base + RCW'({s_e, 1'b0}) > rows_e);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      pcol <= '0; bcol <= '0; prow <= '0; wbc <= '0; wbr <= '0;
      col_base <= '0; row_base <= '0;
    end else if (cmd.accept) begin
      if (row_end) begin
        pcol <= '0; bcol <= '0; wbc <= '0; col_base <= '0;
        if (frame_end) begin
          prow <= '0; wbr <= '0; row_base <= '0;
        end else begin
          prow <= prow + 1'b1;
          if (wbr_wrap) begin
            wbr      <= '0;
            row_base <= row_base + RCW'(s_e);
          end else begin
            wbr <= wbr + 1'b1;
          end
        end
      end else begin
        pcol <= pcol + 1'b1;
        if (wbc_wrap) begin
          wbc      <= '0;
          bcol     <= bcol + 1'b1;
          col_base <= col_base + CCW'(s_e);
        end else begin
          wbc <= wbc + 1'b1;
        end
      end
    end
  end

  // ---- pixel latch ----
  logic [2:0][CHAN_W-1:0] pix;
  logic [CW-1:0]          addr_q;
  logic                   first_q, last_q, done_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix     <= s_tdata;
      addr_q  <= bcol;
      first_q <= first_now;
      last_q  <= last_now;
      done_q  <= done_now;
    end
  end
  assign st.last_q = last_q;

  // ---- column sums, {red, green, blue} ----
  logic [3*ACC_W-1:0]    rd_data, wr_data;
  logic [2:0][ACC_W-1:0] sum;

  rgbbox_ram #(.WIDTH(3 * ACC_W), .DEPTH(MAX_WIDTH)) u_sums (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (addr_q),
    .wdata (wr_data),
    .raddr (bcol),
    .rdata (rd_data)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = first_q ? ACC_W'(pix[c])
                       : rd_data[c*ACC_W +: ACC_W] + ACC_W'(pix[c]);
    end
  end
  assign wr_data = sum;

  // ---- restoring divider, one quotient bit per cycle, three lanes ----
  logic [SQ_W-1:0]       divisor;
  logic [2:0][SQ_W-1:0]  rem, rem_next;
  logic [2:0][ACC_W-1:0] quo, quo_next;
  logic [DCW-1:0]        div_cnt;
  logic [SQ_W:0]         trial [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem[c], quo[c][ACC_W-1]};
      if (trial[c] >= {1'b0, divisor}) begin
        rem_next[c] = SQ_W'(trial[c] - {1'b0, divisor});
        quo_next[c] = {quo[c][ACC_W-2:0], 1'b1};
      end else begin
        rem_next[c] = trial[c][SQ_W-1:0];
        quo_next[c] = {quo[c][ACC_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      divisor <= SQ_W'(s_e) * SQ_W'(s_e);
      rem     <= '0;
      quo     <= sum;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_next;
      quo     <= quo_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end
  assign st.div_done = div_cnt == DCW'(ACC_W - 1);

  // ---- output register ----
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {quo[2][CHAN_W-1:0], quo[1][CHAN_W-1:0], quo[0][CHAN_W-1:0]};
      m_tuser <= done_q;
    end
  end

  assign m_tvalid    = out_valid;
  assign st.out_free = !out_valid || m_tready;

  `ASSERT_IMPL(a_we_after_accept, clk, rst, cmd.acc, $past(cmd.accept))
  `ASSERT_IMPL(a_load_when_free, clk, rst, cmd.load, !out_valid || m_tready)
  `ASSERT_IMPL(a_div_in_range, clk, rst, cmd.div_step, int'(div_cnt) < ACC_W)

endmodule

// ===== src/rgb_box_average_downscale.sv =====
// Sequence: a block's closing pixel gives its result after one accumulate, ACC_W divider
//   steps and one load; the sum read overlaps the transfer. A waiting result holds the
//   load step. No new pixel is taken until the controller is back in idle.
// Throughput: one pixel per cycle outside whole blocks; a pixel inside a block also takes
//   a sum RAM read then write, and a block's last pixel waits for the bit-serial divider.
// Reset: synchronous, active high; registers to 480 x 640, scale 2, counters to zero.
//   Column sums are not cleared: a block's first pixel always overwrites its entry.
module rgb_box_average_downscale import rgbbox_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic                clk,
  input  logic                rst,
  // config port, registers at 0x0 rows, 0x4 cols, 0x8 scale
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // pixel input
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [3*CHAN_W-1:0] s_tdata,   // red_in, green_in, blue_in
  // averaged pixel output
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [3*CHAN_W-1:0] m_tdata,   // red_out, green_out, blue_out
  output logic [0:0]          m_tuser    // frame_done
);

  cmd_t    cmd;
  status_t st;

  assign pready = 1'b1;

  // Controller sequences each pixel: accept, accumulate if in a whole block, divide and load for a block's last pixel.
  rgbbox_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: registers, raster counters, column-sum RAM, divider, output register.
  // The output register lets the next pixel transfer while a result waits.
  rgbbox_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_SCALE(MAX_SCALE)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
